// ----- rtl/core/olde_pkg.sv -----
// Shared types, codes and constants for the ordered list delete engine.
package olde_pkg;

    // Default store depth
    localparam int CAPACITY_DEF = 64;

    // Field widths
    localparam int OPC_W = 2;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int STS_W = 3;
    localparam int CNT_W = 7;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OPC_W-1:0] OP_DEL_VAL = 2'd1;
    localparam logic [OPC_W-1:0] OP_DEL_POS = 2'd2;

    // Status codes
    localparam logic [STS_W-1:0] ST_APPENDED     = 3'd0;
    localparam logic [STS_W-1:0] ST_DELETED      = 3'd1;
    localparam logic [STS_W-1:0] ST_EMPTY        = 3'd2;
    localparam logic [STS_W-1:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [STS_W-1:0] ST_INVALID      = 3'd4;
    localparam logic [STS_W-1:0] ST_OUT_OF_RANGE = 3'd5;
    localparam logic [STS_W-1:0] ST_FULL         = 3'd6;

    // Request payload
    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } req_t;

    // Response payload
    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [CNT_W-1:0] count;
    } rsp_t;

    // Engine completion toward the output register
    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } done_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

endpackage

// ----- rtl/core/olde_engine.sv -----
// List store and sequencer: append, search by value and shift-down delete.
module olde_engine #(
    parameter int CAPACITY = olde_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  olde_pkg::req_t  req,
    input  logic            rsp_free,
    output logic            busy,
    output olde_pkg::done_t done
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    // Entry store, one write and one registered read per cycle
    logic [olde_pkg::VAL_W-1:0] mem [CAPACITY];
    logic [olde_pkg::VAL_W-1:0] rd_data_reg;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [olde_pkg::VAL_W-1:0] wr_data;
    logic [AW-1:0]              rd_addr;

    olde_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] idx_inc;
    logic [olde_pkg::OPC_W-1:0] op_reg;
    logic [olde_pkg::VAL_W-1:0] val_reg;
    logic [olde_pkg::POS_W-1:0] pos_reg;
    logic [olde_pkg::STS_W-1:0] status_reg, status_next;
    logic full;
    logic empty;
    logic pos_bad;
    logic pos_high;
    logic hit;
    logic last_srch;
    logic more_shift;

    // Shared compare and increment unit
    assign idx_inc    = idx_reg + CW'(1);
    assign full       = (count_reg >= CW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign pos_bad    = empty || (pos_reg == '0);
    assign pos_high   = ({1'b0, pos_reg} > 9'(count_reg));
    assign hit        = (rd_data_reg == val_reg);
    assign last_srch  = (idx_inc >= count_reg);
    assign more_shift = (idx_inc < count_reg);

    // Store access
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olde_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == olde_pkg::S_IDLE && start)
        begin
            op_reg  <= req.opcode;
            val_reg <= req.value;
            pos_reg <= req.position;
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olde_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = olde_pkg::S_DECODE;
                end
            end
            olde_pkg::S_DECODE:
            begin
                case (op_reg)
                    olde_pkg::OP_DEL_VAL:
                        state_next = empty ? olde_pkg::S_FINISH : olde_pkg::S_SRCH_RD;
                    olde_pkg::OP_DEL_POS:
                        state_next = (pos_bad || pos_high) ? olde_pkg::S_FINISH
                                                           : olde_pkg::S_SHIFT_RD;
                    default:
                        state_next = olde_pkg::S_FINISH;
                endcase
            end
            olde_pkg::S_SRCH_RD:
                state_next = olde_pkg::S_SRCH_CMP;
            olde_pkg::S_SRCH_CMP:
            begin
                if (hit)
                begin
                    state_next = olde_pkg::S_SHIFT_RD;
                end
                else if (last_srch)
                begin
                    state_next = olde_pkg::S_FINISH;
                end
                else
                begin
                    state_next = olde_pkg::S_SRCH_RD;
                end
            end
            olde_pkg::S_SHIFT_RD:
                state_next = more_shift ? olde_pkg::S_SHIFT_WR : olde_pkg::S_FINISH;
            olde_pkg::S_SHIFT_WR:
                state_next = olde_pkg::S_SHIFT_RD;
            olde_pkg::S_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = olde_pkg::S_IDLE;
                end
            end
            default:
                state_next = olde_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and outputs
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rd_data_reg;
        rd_addr     = idx_reg[AW-1:0];
        idx_next    = idx_reg;
        count_next  = count_reg;
        status_next = status_reg;
        case (state_reg)
            olde_pkg::S_DECODE:
            begin
                case (op_reg)
                    olde_pkg::OP_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = olde_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[AW-1:0];
                            wr_data     = val_reg;
                            count_next  = count_reg + CW'(1);
                            status_next = olde_pkg::ST_APPENDED;
                        end
                    end
                    olde_pkg::OP_DEL_VAL:
                    begin
                        idx_next    = '0;
                        status_next = olde_pkg::ST_EMPTY;
                    end
                    olde_pkg::OP_DEL_POS:
                    begin
                        idx_next = CW'(pos_reg - 8'd1);
                        if (pos_bad)
                        begin
                            status_next = olde_pkg::ST_INVALID;
                        end
                        else if (pos_high)
                        begin
                            status_next = olde_pkg::ST_OUT_OF_RANGE;
                        end
                    end
                    default:
                        status_next = olde_pkg::ST_INVALID;
                endcase
            end
            olde_pkg::S_SRCH_CMP:
            begin
                if (!hit)
                begin
                    idx_next    = idx_inc;
                    status_next = olde_pkg::ST_NOT_FOUND;
                end
            end
            olde_pkg::S_SHIFT_RD:
            begin
                // Fetch the next entry, or close out the delete at the tail
                rd_addr = idx_inc[AW-1:0];
                if (!more_shift)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = olde_pkg::ST_DELETED;
                end
            end
            olde_pkg::S_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    assign busy            = (state_reg != olde_pkg::S_IDLE);
    assign done.valid      = (state_reg == olde_pkg::S_FINISH) && rsp_free;
    assign done.rsp.status = status_reg;
    assign done.rsp.count  = olde_pkg::CNT_W'(count_reg);

endmodule

// ----- rtl/core/ordered_list_delete_engine_core.sv -----
// Top level of the ordered list delete engine: request intake and response register.
//
// Usage:
//   Request channel (req_valid, req_stall, req) carries opcode, value and
//   position. A request is taken at a rising edge with req_valid high and
//   req_stall low. One request is worked on at a time; req_stall stays high
//   from the cycle after acceptance until the sequencer returns to idle.
//   Response channel (rsp_valid, rsp_stall, rsp) gives one status and the
//   new entry count per request, held in an output register.
//   Append and all rejected requests pass through decode and finish; the
//   sequencer is idle again, able to take the next request, once their
//   response enters the output register. Delete by value reads and
//   compares each entry scanned, then reads and writes each entry moved
//   down; delete by position only moves entries down.
//   Reset clears the entry count and sequencer; store contents are not
//   cleared, since only entries below the count are ever used.
//   A stalled response holds in the output register; a finished request
//   waits in the sequencer until the register frees, and a new request
//   can be taken while the previous response still waits.
module ordered_list_delete_engine_core #(
    parameter int CAPACITY = olde_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  olde_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output olde_pkg::rsp_t rsp
);

    logic            busy;
    logic            rsp_free;
    logic            start;
    olde_pkg::done_t done;
    logic            rsp_valid_reg, rsp_valid_next;
    olde_pkg::rsp_t  rsp_reg;

    assign req_stall = busy;
    assign start     = req_valid && !busy;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    olde_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .rsp_free (rsp_free),
        .busy     (busy),
        .done     (done)
    );

    // Response register
    always_comb
    begin
        rsp_valid_next = done.valid || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.valid)
        begin
            rsp_reg <= done.rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // An accepted request keeps the intake closed in the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("intake open right after a request was taken");

    // A finished request never overwrites a waiting response
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        done.valid |-> (!rsp_valid_reg || !rsp_stall))
        else $error("response register overwritten while stalled");

    // Reported count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp.count) <= CAPACITY))
        else $error("count above capacity");
`endif

endmodule

// ----- verif/ordered_list_delete_checker.sv -----
// Checker for the ordered list delete engine: predicts each response and compares it.
module ordered_list_delete_checker #(
    parameter int CAPACITY = olde_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  olde_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  olde_pkg::rsp_t rsp,
    output int             mismatches,
    output int             outstanding
);
    import olde_pkg::*;

    // Shadow copy of the list contents and its length
    logic [VAL_W-1:0] shadow_list [CAPACITY];
    int unsigned      shadow_len;

    // Status and count owed for each accepted request, oldest first
    rsp_t owed_replies [$];

    // Drop slot idx and close the gap
    function automatic void close_gap(int unsigned idx);
        for (int unsigned k = idx; k + 1 < shadow_len && k + 1 < CAPACITY; k++)
        begin
            shadow_list[k] = shadow_list[k + 1];
        end
        shadow_len--;
    endfunction

    // Apply one request to the shadow list and return the response it should give
    function automatic rsp_t apply_list_op(req_t r);
        rsp_t        res;
        logic        hit;
        int unsigned k;
        hit = 1'b0;
        case (r.opcode)
            OP_APPEND:
            begin
                if (shadow_len >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    shadow_list[shadow_len] = r.value;
                    shadow_len++;
                    res.status = ST_APPENDED;
                end
            end
            OP_DEL_VAL:
            begin
                if (shadow_len == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    res.status = ST_NOT_FOUND;
                    for (k = 0; k < shadow_len && !hit; k++)
                    begin
                        if (shadow_list[k] == r.value)
                        begin
                            close_gap(k);
                            res.status = ST_DELETED;
                            hit = 1'b1;
                        end
                    end
                end
            end
            OP_DEL_POS:
            begin
                if (shadow_len == 0 || r.position == 0)
                begin
                    res.status = ST_INVALID;
                end
                else if (r.position > shadow_len)
                begin
                    res.status = ST_OUT_OF_RANGE;
                end
                else
                begin
                    close_gap(r.position - 1);
                    res.status = ST_DELETED;
                end
            end
            default:
            begin
                res.status = ST_INVALID;
            end
        endcase
        res.count = CNT_W'(shadow_len);
        return res;
    endfunction

    // Watch both channels: check responses first, then predict the new request
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            shadow_len = 0;
            owed_replies.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_replies.size() == 0)
                begin
                    $display("%0t: response with none pending: status %0d count %0d",
                             $time, rsp.status, rsp.count);
                    mismatches++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.count !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, rsp.count);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
            begin
                owed_replies.push_back(apply_list_op(req));
            end
            outstanding = owed_replies.size();
        end
    end

endmodule

// ----- verif/ordered_list_delete_engine_core_test.sv -----
// Testbench top for the ordered list delete engine: clock, reset, requests and verdict.
module ordered_list_delete_engine_core_test;
    import olde_pkg::*;

    // Opcode with no defined meaning
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_REQS = 1080;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   mismatches;
    int   outstanding;

    // Stretches with no idling on either side
    bit no_gaps;

    // Candidate values, so deletes by value find matches and duplicates
    logic [VAL_W-1:0] value_pool [16];

    ordered_list_delete_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    ordered_list_delete_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic req_t make_req(logic [OPC_W-1:0] op, logic [VAL_W-1:0] val,
                                      logic [POS_W-1:0] pos);
        req_t r;
        r.opcode = op;
        r.value = val;
        r.position = pos;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 15)];
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(0, 255));
        return POS_W'($urandom_range(0, 68));
    endfunction

    // Set the four extreme values and refresh the rest of the value pool
    task automatic reseed_pool();
        value_pool[0] = 32'h7FFF_FFFF;
        value_pool[1] = 32'h8000_0000;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 16; i++)
        begin
            value_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 31);
        end
    endtask

    // Send one request after a random idle gap, possibly none; called and returns at a falling edge
    task automatic send_request(req_t item);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // Response side: stall for a random number of cycles before each response
    initial
    begin : rsp_side
        int n;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = draw_wait();
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
        end
    end

    // Request side and verdict
    initial
    begin : req_side
        int sent;
        int phase_len;
        int mode;
        int roll;
        logic [OPC_W-1:0] op;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        no_gaps = 1'b0;
        reseed_pool();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty list cases, extremes, duplicates, rejections
        send_request(make_req(OP_DEL_VAL, 32'd5, 8'd0));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd1));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd0));
        send_request(make_req(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF));
        send_request(make_req(OP_APPEND, 32'h7FFF_FFFF, 8'd0));
        send_request(make_req(OP_APPEND, 32'h8000_0000, 8'd0));
        send_request(make_req(OP_APPEND, 32'h0000_0000, 8'd0));
        send_request(make_req(OP_APPEND, 32'hFFFF_FFFF, 8'd0));
        send_request(make_req(OP_APPEND, 32'd5, 8'd0));
        send_request(make_req(OP_APPEND, 32'd5, 8'd0));
        // duplicate: only the first 5 goes
        send_request(make_req(OP_DEL_VAL, 32'd5, 8'd0));
        send_request(make_req(OP_DEL_VAL, 32'd99, 8'd0));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd0));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd6));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd255));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd5));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd1));
        send_request(make_req(OP_UNUSED, 32'd0, 8'd1));
        send_request(make_req(OP_DEL_VAL, 32'h8000_0000, 8'd0));
        send_request(make_req(OP_DEL_VAL, 32'hFFFF_FFFF, 8'd0));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd1));
        // fill to capacity, then overflow and delete at both ends
        repeat (CAPACITY_DEF) send_request(make_req(OP_APPEND, pick_value(), 8'd0));
        send_request(make_req(OP_APPEND, 32'd1, 8'd0));
        send_request(make_req(OP_DEL_POS, 32'd0, POS_W'(CAPACITY_DEF + 1)));
        send_request(make_req(OP_DEL_POS, 32'd0, POS_W'(CAPACITY_DEF)));
        send_request(make_req(OP_DEL_POS, 32'd0, 8'd1));

        // Random: phases that lean toward filling, draining or a mix
        sent = 0;
        while (sent < RANDOM_REQS)
        begin
            phase_len = $urandom_range(20, 80);
            mode = $urandom_range(0, 2);
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0)
                reseed_pool();
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0: op = (roll < 65) ? OP_APPEND : (roll < 82) ? OP_DEL_VAL :
                            (roll < 97) ? OP_DEL_POS : OP_UNUSED;
                    1: op = (roll < 20) ? OP_APPEND : (roll < 58) ? OP_DEL_VAL :
                            (roll < 96) ? OP_DEL_POS : OP_UNUSED;
                    default: op = (roll < 40) ? OP_APPEND : (roll < 68) ? OP_DEL_VAL :
                                  (roll < 97) ? OP_DEL_POS : OP_UNUSED;
                endcase
                send_request(make_req(op, pick_value(), pick_position()));
                sent++;
            end
        end
        req_valid <= 1'b0;

        // Drain outstanding responses, then a short settle
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial
    begin
        #12_800_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/olde_pkg.sv
rtl/core/olde_engine.sv
rtl/core/ordered_list_delete_engine_core.sv
verif/ordered_list_delete_checker.sv
verif/ordered_list_delete_engine_core_test.sv
